FILE: hdl/irtl_pkg.sv
// ----------------------------------------------------------------------------
// irtl_pkg
// Shared types and constants for the interval range table lookup block.
// ----------------------------------------------------------------------------
package irtl_pkg;

  localparam int CP_W            = 21;
  localparam int CLASS_W         = 5;
  localparam int IDX_W           = 12;
  localparam int COUNT_W         = 13;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // register select, taken from paddr bit 2
  typedef enum logic [0:0] {
    REG_ENTRY_COUNT   = 1'b0,
    REG_DEFAULT_CLASS = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [0:0]         operation;
    logic [IDX_W-1:0]   entry_index;
    logic [CP_W-1:0]    range_start;
    logic [CP_W-1:0]    range_end;
    logic [CLASS_W-1:0] range_class;
    logic [CP_W-1:0]    code_point;
  } in_req_t;

  typedef struct packed {
    logic               found;
    logic [CLASS_W-1:0] point_class;
    logic [IDX_W-1:0]   match_index;
  } out_rsp_t;

  typedef struct packed {
    logic [CP_W-1:0]    lo;
    logic [CP_W-1:0]    hi;
    logic [CLASS_W-1:0] cls;
  } entry_t;

  // classified request as it sits in the queue
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
    logic [CP_W-1:0]  cp;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHK_FIRST,
    BK_CHK_LAST,
    BK_PROBE,
    BK_DONE
  } bk_state_t;

endpackage

FILE: hdl/irtl_front.sv
// ----------------------------------------------------------------------------
// irtl_front
// Request intake: decodes the operation and drops writes beyond the table.
// ----------------------------------------------------------------------------
module irtl_front import irtl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic    in_valid,
  output logic    in_stall,
  input  in_req_t in_req,
  input  q_stat_t q_stat,
  output logic    push,
  output cmd_t    cmd
);

  localparam int DW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (IDX_W > DW) ? IDX_W : DW;

  logic accept;
  logic idx_ok;
  logic is_lookup;

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign is_lookup = (in_req.operation == OP_LOOKUP);
  assign idx_ok    = (XW'(in_req.entry_index) < XW'(TABLE_DEPTH));

  // out-of-range writes are consumed but never queued
  assign push = accept && (is_lookup || idx_ok);

  always_comb begin
    cmd.op      = is_lookup ? OP_LOOKUP : OP_WRITE;
    cmd.idx     = in_req.entry_index;
    cmd.ent.lo  = in_req.range_start;
    cmd.ent.hi  = in_req.range_end;
    cmd.ent.cls = in_req.range_class;
    cmd.cp      = in_req.code_point;
  end

endmodule

FILE: hdl/irtl_queue.sv
// ----------------------------------------------------------------------------
// irtl_queue
// Short FIFO of classified requests between intake and search engine.
// ----------------------------------------------------------------------------
module irtl_queue import irtl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          q_mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign q_stat.full  = (cnt_r == NW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_cmd     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/irtl_back.sv
// ----------------------------------------------------------------------------
// irtl_back
// Range table memory, bound check and binary search engine, result register.
// ----------------------------------------------------------------------------
module irtl_back import irtl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  q_stat_t            q_stat,
  input  cmd_t               head_cmd,
  output logic               pop,
  input  logic [COUNT_W-1:0] entry_count,
  input  logic [CLASS_W-1:0] default_class,
  output logic               out_valid,
  input  logic               out_stall,
  output out_rsp_t           out_rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (COUNT_W > CW) ? COUNT_W : CW;

  entry_t             tbl_mem [TABLE_DEPTH];
  entry_t             rd_ent_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;

  bk_state_t          state_r, state_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [AW-1:0]      m_r, m_nxt;
  logic [CP_W-1:0]    cp_r, cp_nxt;
  out_rsp_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_rsp_r, out_rsp_nxt;
  logic [CW-1:0]      n_cnt;
  out_rsp_t           miss_rsp;

  // midpoint of the open window [a, b)
  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s      = {1'b0, a} + {1'b0, b} - (CW + 1)'(1);
    mid_of = AW'(s >> 1);
  endfunction

  // count above the depth acts as the depth
  assign n_cnt = (EW'(entry_count) > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entry_count);

  always_comb begin
    miss_rsp.found       = 1'b0;
    miss_rsp.point_class = default_class;
    miss_rsp.match_index = '0;
  end

  assign mem_waddr = AW'(head_cmd.idx);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = '0;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    m_nxt         = m_r;
    cp_nxt        = cp_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (head_cmd.op == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            cp_nxt = head_cmd.cp;
            if (n_cnt == '0) begin
              res_nxt   = miss_rsp;
              state_nxt = BK_DONE;
            end else begin
              mem_raddr = '0;
              state_nxt = BK_CHK_FIRST;
            end
          end
        end
      end
      BK_CHK_FIRST: begin
        if (cp_r < rd_ent_r.lo) begin
          res_nxt   = miss_rsp;
          state_nxt = BK_DONE;
        end else begin
          mem_raddr = AW'(n_cnt - CW'(1));
          state_nxt = BK_CHK_LAST;
        end
      end
      BK_CHK_LAST: begin
        if (cp_r > rd_ent_r.hi) begin
          res_nxt   = miss_rsp;
          state_nxt = BK_DONE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = n_cnt;
          m_nxt     = mid_of('0, n_cnt);
          mem_raddr = m_nxt;
          state_nxt = BK_PROBE;
        end
      end
      BK_PROBE: begin
        if (cp_r > rd_ent_r.hi || cp_r < rd_ent_r.lo) begin
          if (cp_r > rd_ent_r.hi) begin
            lo_nxt = CW'(m_r) + CW'(1);
          end else begin
            hi_nxt = CW'(m_r);
          end
          if (lo_nxt < hi_nxt) begin
            m_nxt     = mid_of(lo_nxt, hi_nxt);
            mem_raddr = m_nxt;
          end else begin
            res_nxt   = miss_rsp;
            state_nxt = BK_DONE;
          end
        end else begin
          res_nxt.found       = 1'b1;
          res_nxt.point_class = rd_ent_r.cls;
          res_nxt.match_index = IDX_W'(m_r);
          state_nxt           = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = res_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    m_r       <= m_nxt;
    cp_r      <= cp_nxt;
    res_r     <= res_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= head_cmd.ent;
    end
    rd_ent_r <= tbl_mem[mem_raddr];
  end

endmodule

FILE: hdl/interval_range_table_lookup.sv
// A request enters the queue at acceptance; the engine pops it from the head in BK_IDLE.
// Write request: retires in BK_IDLE. Lookup: BK_IDLE, then for n > 0 valid entries the bound
// reads in BK_CHK_FIRST and BK_CHK_LAST and up to floor(log2(n)) + 1 probes, then BK_DONE.
// The range table has one write port and one read port: one table read per engine cycle.
// Reset (rst_n, synchronous): clears queue, engine state, output valid and both config regs;
// table contents stay undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// interval_range_table_lookup
// Classifies code points by binary search over a table of sorted ranges.
// ----------------------------------------------------------------------------
module interval_range_table_lookup import irtl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_req,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_rsp_t              out_rsp,
  // APB-style config port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // config registers: entry_count at 0x0, default_class at 0x4
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [CLASS_W-1:0] dflt_r, dflt_nxt;
  logic               cfg_we;
  reg_sel_t           cfg_sel;

  // front -> queue -> back
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cmd_t    q_in_cmd;
  cmd_t    q_head_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // byte address bit 2 picks the register; low bits are ignored
  assign cfg_sel    = reg_sel_t'(cfg_paddr[2]);

  always_comb begin
    cnt_nxt  = cnt_r;
    dflt_nxt = dflt_r;
    if (cfg_we) begin
      case (cfg_sel)
        REG_ENTRY_COUNT:   cnt_nxt  = cfg_pwdata[COUNT_W-1:0];
        REG_DEFAULT_CLASS: dflt_nxt = cfg_pwdata[CLASS_W-1:0];
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ENTRY_COUNT:   cfg_prdata = CFG_DATA_W'(cnt_r);
      REG_DEFAULT_CLASS: cfg_prdata = CFG_DATA_W'(dflt_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      dflt_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      dflt_r <= dflt_nxt;
    end
  end

  // intake: decode and filter requests
  irtl_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_stat   (q_stat),
    .push     (q_push),
    .cmd      (q_in_cmd)
  );

  // decoupling queue so intake keeps taking requests during a search until the queue is full
  irtl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .q_stat   (q_stat)
  );

  // table writes, bound check, binary search, result register
  irtl_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head_cmd      (q_head_cmd),
    .pop           (q_pop),
    .entry_count   (cnt_r),
    .default_class (dflt_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rsp       (out_rsp)
  );

  // a miss always reports index 0
  a_miss_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.found) |-> (out_rsp.match_index == '0))
    else $error("miss with nonzero match_index");

  // a miss carries the configured default class
  a_miss_default: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.found) |-> (out_rsp.point_class == dflt_r))
    else $error("miss class differs from default_class");

  // config write lands in entry_count
  a_cfg_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_sel == REG_ENTRY_COUNT) |=> (cnt_r == $past(cfg_pwdata[COUNT_W-1:0])))
    else $error("entry_count write lost");

  // queue never pushed while full
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_push)
    else $error("request queue overflow");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for interval_range_table_lookup: a directed table of
// requests and register writes, then random phases that load range tables,
// set the entry count and default class, and stream lookups. Every result is
// compared against an in-bench binary search over a shadow copy of the table.
// ----------------------------------------------------------------------------
module testbench;
  import irtl_pkg::*;

  localparam int IDLE_PCT      = 18;       // idle cycles per hundred, each side
  localparam int HOLD_CYCLES   = 300;      // long result-side hold-off
  localparam int SETTLE_CYCLES = 40;       // > worst lookup latency plus queue
  localparam int RAND_ITEMS    = 1000;     // random requests, every phase counted
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int BIG_PHASE     = 1;        // phase that runs counts at full depth
  localparam int HOLD_PHASE    = 3;        // phase with the long hold-off
  localparam int SLOT          = (1 << CP_W) / TABLE_DEPTH_DEF;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // one line of the directed plan: a request or a register write
  typedef struct {
    row_kind_t   kind;
    reg_sel_t    sel;
    logic [31:0] value;
    in_req_t     req;
    bit          pinned;   // expected result typed in below, not predicted
    out_rsp_t    rsp;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_req_t               in_req      = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_rsp_t              out_rsp;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  interval_range_table_lookup dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rsp     (out_rsp),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Shadow state: range table, which entries were written, both registers.
  // --------------------------------------------------------------------------
  entry_t             range_shadow [TABLE_DEPTH_DEF];
  bit                 entry_loaded [TABLE_DEPTH_DEF];
  logic [COUNT_W-1:0] count_shadow = '0;
  logic [CLASS_W-1:0] dflt_shadow  = '0;

  out_rsp_t awaited_lookups [$];   // classifications still owed by the block
  plan_row_t plan [$];
  int        spine [$];            // right-hand search path over the full table

  int  errors       = 0;
  int  cycle_count  = 0;
  int  lookups_sent = 0;
  int  writes_sent  = 0;
  int  reg_writes   = 0;
  int  stall_cycles = 0;
  int  hold_left    = 0;
  bit  hold_req     = 1'b0;
  bit  quiet        = 1'b0;        // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d lookups still owed", $time,
               awaited_lookups.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: bound check on the first and last valid entry, then a binary
  // search. Counts above the table depth are clamped to the depth.
  // --------------------------------------------------------------------------
  function automatic out_rsp_t classify_point(logic [CP_W-1:0] cp);
    out_rsp_t r;
    int       n;
    int       lo_i;
    int       hi_i;
    int       mid;
    r.found       = 1'b0;
    r.point_class = dflt_shadow;
    r.match_index = '0;
    n = (count_shadow > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(count_shadow);
    if (n > 0 && cp >= range_shadow[0].lo && cp <= range_shadow[n-1].hi) begin
      lo_i = 0;
      hi_i = n - 1;
      // reversed or unsorted entries still shrink the window every probe
      while (hi_i >= lo_i) begin
        mid = (lo_i + hi_i) / 2;
        if (cp > range_shadow[mid].hi) begin
          lo_i = mid + 1;
        end else if (cp < range_shadow[mid].lo) begin
          hi_i = mid - 1;
        end else begin
          r.found       = 1'b1;
          r.point_class = range_shadow[mid].cls;
          r.match_index = IDX_W'(mid);
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic in_req_t junk_req();
    logic [95:0] r;
    r = {$urandom(), $urandom(), $urandom()};
    return r[$bits(in_req_t)-1:0];
  endfunction

  // unused fields carry random bits so every payload bit toggles
  function automatic in_req_t mk_lookup(logic [CP_W-1:0] cp);
    in_req_t req;
    req            = junk_req();
    req.operation  = OP_LOOKUP;
    req.code_point = cp;
    return req;
  endfunction

  function automatic in_req_t mk_write(logic [IDX_W-1:0] idx, logic [CP_W-1:0] lo,
                                       logic [CP_W-1:0] hi, logic [CLASS_W-1:0] cls);
    in_req_t req;
    req             = junk_req();
    req.operation   = OP_WRITE;
    req.entry_index = idx;
    req.range_start = lo;
    req.range_end   = hi;
    req.range_class = cls;
    return req;
  endfunction

  function automatic plan_row_t blank_row();
    plan_row_t row;
    row = '{kind: ROW_REQ, sel: REG_ENTRY_COUNT, value: '0, req: '0, pinned: 1'b0,
            rsp: '0};
    return row;
  endfunction

  function automatic plan_row_t row_look(logic [CP_W-1:0] cp);
    plan_row_t row;
    row        = blank_row();
    row.kind   = ROW_REQ;
    row.req    = mk_lookup(cp);
    return row;
  endfunction

  function automatic plan_row_t row_pin(logic [CP_W-1:0] cp, bit f, int cls, int idx);
    plan_row_t row;
    row                 = row_look(cp);
    row.pinned          = 1'b1;
    row.rsp.found       = f;
    row.rsp.point_class = CLASS_W'(cls);
    row.rsp.match_index = IDX_W'(idx);
    return row;
  endfunction

  function automatic plan_row_t row_write(int idx, int lo, int hi, int cls);
    plan_row_t row;
    row      = blank_row();
    row.kind = ROW_REQ;
    row.req  = mk_write(IDX_W'(idx), CP_W'(lo), CP_W'(hi), CLASS_W'(cls));
    return row;
  endfunction

  function automatic plan_row_t row_cfg(reg_sel_t sel, logic [31:0] value);
    plan_row_t row;
    row       = blank_row();
    row.kind  = ROW_CFG;
    row.sel   = sel;
    row.value = value;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. offer() returns at the accepting edge with in_valid still
  // high; the caller then either offers again or calls settle_input() in the
  // same step, so valid is never dropped and raised within one step.
  // --------------------------------------------------------------------------
  task automatic offer(input in_req_t req, input bit pinned = 1'b0,
                       input out_rsp_t pinned_rsp = '0);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    // accepted: fold into the shadow in request order
    if (req.operation == OP_WRITE) begin
      // a 12-bit index never reaches past the default depth
      range_shadow[req.entry_index] = '{lo: req.range_start, hi: req.range_end,
                                        cls: req.range_class};
      entry_loaded[req.entry_index] = 1'b1;
      writes_sent++;
    end else begin
      awaited_lookups.push_back(pinned ? pinned_rsp : classify_point(req.code_point));
      lookups_sent++;
    end
  endtask

  // drop valid, wait for every owed result, then let trailing writes retire
  task automatic settle_input();
    in_valid <= 1'b0;
    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Config port: setup cycle, access cycle, done when pready is seen.
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input reg_sel_t sel,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // write, mirror the masked value, read back and compare
  task automatic set_reg(input reg_sel_t sel, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] want;
    apb_access(1'b1, sel, value, rd);
    if (sel == REG_ENTRY_COUNT) begin
      count_shadow = value[COUNT_W-1:0];
      want         = 32'(count_shadow);
    end else begin
      dflt_shadow = value[CLASS_W-1:0];
      want        = 32'(dflt_shadow);
    end
    reg_writes++;
    apb_access(1'b0, sel, 32'h0, rd);
    if (rd !== want) begin
      $display("%0t: register %s readback: expected %0h, got %0h", $time, sel.name(),
               want, rd);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------

  // Loads entries 0..k-1. Sorted layout gives each entry its own slice of
  // code space, with a few reversed ranges; jumbled layout is pure noise.
  task automatic load_ranges(input int k, input bit jumbled);
    int               budget;
    int               base;
    logic [CP_W-1:0]  lo;
    logic [CP_W-1:0]  hi;
    logic [CP_W-1:0]  t;
    budget = (1 << CP_W) / k;
    for (int i = 0; i < k; i++) begin
      if (jumbled) begin
        lo = CP_W'($urandom());
        hi = CP_W'($urandom());
      end else begin
        base = i * budget;
        lo   = CP_W'(base + $urandom_range(0, budget / 2));
        hi   = lo + CP_W'($urandom_range(0, budget / 2 - 1));
        if (i == 0 && $urandom_range(4) == 0) lo = '0;
        if (i == k - 1 && $urandom_range(4) == 0) hi = '1;
        if ($urandom_range(99) < 5) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
      end
      offer(mk_write(IDX_W'(i), lo, hi, CLASS_W'($urandom())));
    end
  endtask

  // sorted range inside the entry's own slot of code space
  task automatic write_slot(input int idx);
    logic [CP_W-1:0] lo;
    lo = CP_W'(idx * SLOT + 64 + $urandom_range(0, 127));
    offer(mk_write(IDX_W'(idx), lo, lo + CP_W'($urandom_range(0, 255)),
                   CLASS_W'($urandom())));
  endtask

  // Entry 0 plus every entry a full-depth search visits while it keeps
  // stepping right; lookups that stay on that path touch nothing else.
  task automatic load_spine();
    int a;
    int b;
    int mid;
    spine.delete();
    a = 0;
    b = TABLE_DEPTH_DEF - 1;
    while (b >= a) begin
      mid = (a + b) / 2;
      spine.push_back(mid);
      a = mid + 1;
    end
    write_slot(0);
    foreach (spine[i]) write_slot(spine[i]);
  endtask

  // points inside a path entry, below the first entry or above the last one
  task automatic spine_burst(input int m);
    int              pick;
    int              room;
    entry_t          ent;
    logic [CP_W-1:0] cp;
    for (int i = 0; i < m; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        ent = range_shadow[spine[$urandom_range(0, spine.size() - 1)]];
        cp  = ent.lo + CP_W'($urandom_range(0, ent.hi - ent.lo));
      end else if (pick < 85) begin
        cp = CP_W'($urandom_range(0, range_shadow[0].lo - 1));
      end else begin
        room = (1 << CP_W) - 1 - int'(range_shadow[TABLE_DEPTH_DEF-1].hi);
        cp   = CP_W'(int'(range_shadow[TABLE_DEPTH_DEF-1].hi) + $urandom_range(1, room));
      end
      offer(mk_lookup(cp));
    end
  endtask

  // mostly points inside or at the edge of a loaded range, some anywhere
  function automatic logic [CP_W-1:0] pick_point(int span);
    int              pick;
    entry_t          ent;
    logic [CP_W-1:0] cp;
    pick = $urandom_range(99);
    cp   = CP_W'($urandom());
    if (span > 0 && pick < 80) begin
      ent = range_shadow[$urandom_range(0, span - 1)];
      if (pick < 60) begin
        if (ent.lo <= ent.hi) cp = ent.lo + CP_W'($urandom_range(0, ent.hi - ent.lo));
      end else begin
        case ($urandom_range(3))
          0: cp = ent.lo - 1'b1;
          1: cp = ent.lo;
          2: cp = ent.hi;
          default: cp = ent.hi + 1'b1;
        endcase
      end
    end else if (pick < 85) begin
      cp = '0;
    end else if (pick < 90) begin
      cp = '1;
    end
    return cp;
  endfunction

  // lookups with a sprinkle of stray writes that may break the ordering
  task automatic lookup_burst(input int m, input int span);
    int idx;
    for (int i = 0; i < m; i++) begin
      if ($urandom_range(99) < 8) begin
        idx = (span > 0 && $urandom_range(1)) ? $urandom_range(0, span - 1)
                                              : $urandom_range(0, TABLE_DEPTH_DEF - 1);
        offer(mk_write(IDX_W'(idx), CP_W'($urandom()), CP_W'($urandom()),
                       CLASS_W'($urandom())));
      end else begin
        offer(mk_lookup(pick_point(span)));
      end
    end
  endtask

  // entry count never covers an entry that was never loaded
  task automatic pick_config(input int k);
    int safe;
    int n;
    int pick;
    int cls;
    safe = 0;
    while (safe < TABLE_DEPTH_DEF && entry_loaded[safe]) safe++;
    if (safe == TABLE_DEPTH_DEF) safe = (1 << COUNT_W) - 1;
    pick = $urandom_range(99);
    if (pick < 60) n = k;
    else if (pick < 75) n = $urandom_range(0, k);
    else if (pick < 85) n = 0;
    else n = $urandom_range(0, safe);
    // upper pwdata bits are junk; the register keeps only its own width
    set_reg(REG_ENTRY_COUNT, ($urandom() & ~32'h1FFF) | 32'(n));
    pick = $urandom_range(3);
    cls  = (pick == 0) ? 0 : (pick == 1) ? 31 : $urandom_range(0, 31);
    set_reg(REG_DEFAULT_CLASS, ($urandom() & ~32'h1F) | 32'(cls));
  endtask

  // --------------------------------------------------------------------------
  // Result side: check accepted results, drive out_stall. A hold-off request
  // from the stimulus is counted down here, on its own.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n) begin
      if (in_valid && in_stall) stall_cycles++;
      if (out_valid && !out_stall) begin
        if (awaited_lookups.size() == 0) begin
          $display("%0t: unexpected result: expected none, got found=%0d class=%0d index=%0d",
                   $time, out_rsp.found, out_rsp.point_class, out_rsp.match_index);
          errors++;
        end else begin
          want = awaited_lookups.pop_front();
          if (out_rsp.found !== want.found) begin
            $display("%0t: found: expected %0d, got %0d", $time, want.found, out_rsp.found);
            errors++;
          end
          if (out_rsp.point_class !== want.point_class) begin
            $display("%0t: point_class: expected %0d, got %0d", $time, want.point_class,
                     out_rsp.point_class);
            errors++;
          end
          if (out_rsp.match_index !== want.match_index) begin
            $display("%0t: match_index: expected %0d, got %0d", $time, want.match_index,
                     out_rsp.match_index);
            errors++;
          end
        end
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int big_counts [4];
    int phase;
    int rand_items;
    int k;
    int m;
    big_counts = '{4096, 8191, 4097, 4095};
    phase      = 0;
    rand_items = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan
    // empty table straight out of reset: miss, class 0, index 0
    plan.push_back(row_pin(21'h000000, 0, 0, 0));
    plan.push_back(row_pin(21'h1FFFFF, 0, 0, 0));
    plan.push_back(row_cfg(REG_DEFAULT_CLASS, 32'hFFFF_FFFF));   // keeps 31
    plan.push_back(row_pin(21'h000005, 0, 31, 0));
    plan.push_back(row_write(0, 'h000000, 'h00007F, 1));
    plan.push_back(row_write(1, 'h000100, 'h0001FF, 2));
    plan.push_back(row_write(2, 'h001000, 'h001000, 31));       // single point
    plan.push_back(row_write(3, 'h1FFF00, 'h1FFFFF, 0));        // past 0x10FFFF
    plan.push_back(row_write(4095, 'h1FFFFF, 'h000000, 9));     // reversed, top slot
    plan.push_back(row_cfg(REG_ENTRY_COUNT, 32'hFFFF_E004));     // keeps 4
    plan.push_back(row_pin(21'h000000, 1, 1, 0));
    plan.push_back(row_pin(21'h00007F, 1, 1, 0));
    plan.push_back(row_pin(21'h000080, 0, 31, 0));               // gap between ranges
    plan.push_back(row_pin(21'h001000, 1, 31, 2));
    plan.push_back(row_pin(21'h1FFFFF, 1, 0, 3));
    plan.push_back(row_look(21'h000150));
    plan.push_back(row_look(21'h000FFF));
    plan.push_back(row_write(1, 'h000300, 'h000200, 5));        // reversed inside count
    plan.push_back(row_look(21'h000250));
    plan.push_back(row_look(21'h000100));
    plan.push_back(row_cfg(REG_ENTRY_COUNT, 32'h0000_0001));
    plan.push_back(row_look(21'h00007F));
    plan.push_back(row_look(21'h000080));
    plan.push_back(row_cfg(REG_DEFAULT_CLASS, 32'h0000_0000));
    plan.push_back(row_cfg(REG_ENTRY_COUNT, 32'h0000_0000));
    plan.push_back(row_pin(21'h000000, 0, 0, 0));               // empty again, table loaded

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_input();
        set_reg(plan[i].sel, plan[i].value);
      end else begin
        offer(plan[i].req, plan[i].pinned, plan[i].rsp);
      end
    end

    // random phases: load, settle, configure, look up
    while (rand_items < RAND_ITEMS) begin
      settle_input();
      if (phase == BIG_PHASE) begin
        // search path of the full table, then counts at, above and below the depth
        load_spine();
        rand_items += spine.size() + 1;
        foreach (big_counts[j]) begin
          settle_input();
          set_reg(REG_ENTRY_COUNT, ($urandom() & ~32'h1FFF) | 32'(big_counts[j]));
          set_reg(REG_DEFAULT_CLASS, (j % 2) ? 32'd31 : 32'd0);
          spine_burst(40);
          rand_items += 40;
        end
      end else begin
        quiet = (phase == 2);
        case ($urandom_range(9))
          0: k = 1;
          1: k = $urandom_range(100, 300);
          default: k = $urandom_range(2, 40);
        endcase
        load_ranges(k, $urandom_range(9) == 0);
        settle_input();
        pick_config(k);
        // long result hold-off: the queue fills and the input stalls
        if (phase == HOLD_PHASE) hold_req = 1'b1;
        m = quiet ? 150 : $urandom_range(10, 40);
        lookup_burst(m, k);
        quiet = 1'b0;
        rand_items += k + m;
      end
      phase++;
    end
    settle_input();

    $display("Covered %0d lookups and %0d table writes across %0d register writes,",
             lookups_sent, writes_sent, reg_writes);
    $display("full-depth and oversized counts included; input held off %0d cycles.",
             stall_cycles);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
